// ----- sv/spk_pkg.sv -----
// shared types, constants and round functions for the speck64 cipher
package spk_pkg;

   localparam int WORD_BITS = 32;
   localparam int ROT_A     = 8;
   localparam int ROT_B     = 3;
   localparam int CSR_BITS  = 3;

   typedef logic [WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type x;
      word_type y;
   } pair_type;

   typedef enum logic [CSR_BITS-1:0] {
      CSR_KEY0   = 3'd0,
      CSR_KEY1   = 3'd1,
      CSR_KEY2   = 3'd2,
      CSR_KEY3   = 3'd3,
      CSR_KEYLEN = 3'd4,
      CSR_ROUNDS = 3'd5
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic kinit;
      logic kstep;
      logic load;
      logic step;
      logic out_load;
      logic dec;
   } cmd_type;

   function automatic word_type rotr(input word_type v, input int s);
      rotr = (v >> s) | (v << (WORD_BITS - s));
   endfunction

   function automatic word_type rotl(input word_type v, input int s);
      rotl = (v << s) | (v >> (WORD_BITS - s));
   endfunction

   function automatic pair_type round_fwd(input word_type x, input word_type y,
                                          input word_type k);
      pair_type r;
      r.x = (rotr(x, ROT_A) + y) ^ k;
      r.y = rotl(y, ROT_B) ^ r.x;
      round_fwd = r;
   endfunction

   function automatic pair_type round_inv(input word_type x, input word_type y,
                                          input word_type k);
      pair_type r;
      r.y = rotr(y ^ x, ROT_B);
      r.x = rotl((x ^ k) - r.y, ROT_A);
      round_inv = r;
   endfunction

endpackage

// ----- sv/spk_ctrl.sv -----
// controller: key expansion sequencing, round counter and result handshake
module spk_ctrl import spk_pkg::*; #(
   parameter int MAX_ROUNDS = 27,
   localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [CSR_BITS-1:0] csr_index,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [RW-1:0]       last_idx,
   output logic [RW-1:0]       cnt,
   output cmd_type             cmd
);

   typedef enum logic [1:0] {S_KINIT, S_KEXP, S_IDLE, S_RUN} state_type;

   state_type     state_ff, state_in;
   logic [RW-1:0] cnt_ff, cnt_in;
   logic          dec_ff, dec_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          cfg_write, req_fire, last, hold;

   assign cfg_write  = csr_valid && (csr_index <= CSR_ROUNDS);
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign req_fire   = req_tvalid && req_tready;
   assign last       = dec_ff ? (cnt_ff == '0) : (cnt_ff == last_idx);
   // result register still full: hold on the final round
   assign hold       = last && rsp_valid_ff && !rsp_tready;

   assign cmd.kinit    = (state_ff == S_KINIT);
   assign cmd.kstep    = (state_ff == S_KEXP);
   assign cmd.load     = req_fire;
   assign cmd.step     = (state_ff == S_RUN) && !last;
   assign cmd.out_load = (state_ff == S_RUN) && last && !hold;
   assign cmd.dec      = dec_ff;

   assign cnt        = cnt_ff;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      dec_in       = dec_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         S_KINIT: begin
            cnt_in   = '0;
            state_in = (MAX_ROUNDS > 1) ? S_KEXP : S_IDLE;
         end
         S_KEXP: begin
            if (cnt_ff == RW'(MAX_ROUNDS - 2)) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               dec_in   = req_tuser;
               cnt_in   = req_tuser ? last_idx : '0;
               state_in = S_RUN;
            end
         end
         S_RUN: begin
            if (cmd.out_load) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (cmd.step) begin
               cnt_in = dec_ff ? (cnt_ff - 1'b1) : (cnt_ff + 1'b1);
            end
         end
         default: state_in = S_KINIT;
      endcase
      // any register write re-expands the key table
      if (cfg_write) begin
         state_in = S_KINIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_KINIT;
         cnt_ff       <= '0;
         dec_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         dec_ff       <= dec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_out_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_valid_ff)
      else $error("result load did not raise rsp_tvalid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_run_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RUN) |-> (cnt_ff <= last_idx))
      else $error("round counter beyond last round");

   a_exp_cnt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_KEXP) |-> (cnt_ff <= RW'(MAX_ROUNDS - 2)))
      else $error("key expansion counter out of range");

endmodule

// ----- sv/spk_dp.sv -----
// datapath: config registers, key schedule, round key table and round unit
module spk_dp import spk_pkg::*; #(
   parameter int MAX_ROUNDS = 27,
   localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [WORD_BITS-1:0] csr_data,
   input  logic [63:0]          req_tdata,
   input  cmd_type              cmd,
   input  logic [RW-1:0]        cnt,
   output logic [RW-1:0]        last_idx,
   output logic [63:0]          rsp_tdata
);

   word_type      key0_ff, key1_ff, key2_ff, key3_ff;
   logic [2:0]    key_len_ff;
   logic [4:0]    rounds_ff;
   word_type      lw0_ff, lw1_ff, lw2_ff, ky_ff;
   word_type      x_ff, y_ff;
   word_type      res_l_ff, res_r_ff;
   word_type      key_tbl [MAX_ROUNDS];
   logic          m4;
   word_type      k_first;
   word_type      rkey;
   pair_type      kp, rp;
   logic [4:0]    n_m1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key0_ff    <= '0;
         key1_ff    <= '0;
         key2_ff    <= '0;
         key3_ff    <= '0;
         key_len_ff <= 3'd3;
         rounds_ff  <= 5'd26;
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_KEY0:   key0_ff    <= csr_data;
            CSR_KEY1:   key1_ff    <= csr_data;
            CSR_KEY2:   key2_ff    <= csr_data;
            CSR_KEY3:   key3_ff    <= csr_data;
            CSR_KEYLEN: key_len_ff <= csr_data[2:0];
            CSR_ROUNDS: rounds_ff  <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // saturate round count into 1..MAX_ROUNDS, held as last round index
   always_comb begin
      if (rounds_ff == 5'd0) begin
         n_m1 = 5'd0;
      end else if (rounds_ff > 5'(MAX_ROUNDS)) begin
         n_m1 = 5'(MAX_ROUNDS - 1);
      end else begin
         n_m1 = rounds_ff - 5'd1;
      end
   end
   assign last_idx = n_m1[RW-1:0];

   assign m4      = (key_len_ff == 3'd4);
   assign k_first = m4 ? key3_ff : key2_ff;
   assign kp      = round_fwd(lw0_ff, ky_ff, WORD_BITS'(cnt));

   always_ff @(posedge clock) begin
      if (cmd.kinit) begin
         ky_ff  <= k_first;
         lw0_ff <= m4 ? key2_ff : key1_ff;
         lw1_ff <= m4 ? key1_ff : key0_ff;
         lw2_ff <= key0_ff;
      end else if (cmd.kstep) begin
         ky_ff  <= kp.y;
         lw0_ff <= lw1_ff;
         lw1_ff <= m4 ? lw2_ff : kp.x;
         lw2_ff <= kp.x;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.kinit) begin
         key_tbl[0] <= k_first;
      end else if (cmd.kstep) begin
         key_tbl[RW'(cnt + 1'b1)] <= kp.y;
      end
   end

   assign rkey = key_tbl[cnt];
   assign rp   = cmd.dec ? round_inv(x_ff, y_ff, rkey) : round_fwd(x_ff, y_ff, rkey);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= req_tdata[31:0];
         y_ff <= req_tdata[63:32];
      end else if (cmd.step) begin
         x_ff <= rp.x;
         y_ff <= rp.y;
      end
      if (cmd.out_load) begin
         res_l_ff <= rp.x;
         res_r_ff <= rp.y;
      end
   end

   assign rsp_tdata = {res_r_ff, res_l_ff};

endmodule

// ----- sv/speck64_block_cipher.sv -----
// speck64 block cipher top level: round-iterative core, one round per cycle
// unless a full result register holds the final round; each block runs n
// rounds, n = rounds (1..MAX_ROUNDS); a new block is taken only once the prior
// one leaves the single shared round unit; key table expansion runs after
// reset and each register write; req_tready low meanwhile; csr writes always taken
// reset is synchronous active high and restores the 96-bit all-zero key, 26 rounds
module speck64_block_cipher import spk_pkg::*; #(
   parameter int MAX_ROUNDS = 27
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [63:0]          req_tdata,   // right_word, left_word
   input  logic                 req_tuser,   // func
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [63:0]          rsp_tdata,   // result_right, result_left
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [WORD_BITS-1:0] csr_data
);

   localparam int RW = (MAX_ROUNDS > 1) ? $clog2(MAX_ROUNDS) : 1;

   cmd_type       cmd;
   logic [RW-1:0] cnt;
   logic [RW-1:0] last_idx;

   assign csr_ready = 1'b1;

   spk_ctrl #(.MAX_ROUNDS(MAX_ROUNDS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .last_idx   (last_idx),
      .cnt        (cnt),
      .cmd        (cmd)
   );

   spk_dp #(.MAX_ROUNDS(MAX_ROUNDS)) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .cnt       (cnt),
      .last_idx  (last_idx),
      .rsp_tdata (rsp_tdata)
   );

endmodule
